/* design/rmq_pkg.sv */
// Package for the rotation matrix to quaternion unit.
// Holds the shared field width and the output saturation limits.
package rmq_pkg;
  localparam int FIELD_W = 23;
  localparam logic signed [FIELD_W-1:0] OUT_MAX = 23'sd4194303;
  localparam logic signed [FIELD_W-1:0] OUT_MIN = -23'sd4194304;
endpackage

/* design/rmq_sqrt_cell.sv */
// One step of the restoring integer square root: fixes one result bit per cycle.
// Depends on nothing; the payload carried alongside travels in the chain.
module rmq_sqrt_cell #(
  parameter int RW = 48,
  parameter int SW = 24,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [RW-1:0] rem_i,
  input  logic [SW-1:0] root_i,
  input  logic [RW-1:0] rad_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [RW-1:0] rem_o,
  output logic [SW-1:0] root_o,
  output logic [RW-1:0] rad_o,
  output logic [PW-1:0] pay_o
);
  logic [RW+1:0] trial;
  logic [RW+1:0] cur;
  always_comb begin
    cur   = {rem_i, 2'(rad_i[RW-1 -: 2])} ;
    trial = {2'b0, RW'(root_i) << 2 | RW'(1)};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else        vld_o <= vld_i;
    pay_o <= pay_i;
    rad_o <= rad_i << 2;
    if (cur >= trial) begin
      rem_o  <= RW'(cur - trial);
      root_o <= SW'({root_i, 1'b1});
    end else begin
      rem_o  <= RW'(cur);
      root_o <= SW'({root_i, 1'b0});
    end
  end
endmodule

/* design/rmq_div_cell.sv */
// One step of a restoring divider: one quotient bit per cycle, divisor rides along.
// Depends on nothing; lanes for three quotients sit side by side in one cell.
module rmq_div_cell #(
  parameter int NW = 48,
  parameter int DW = 26,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic [DW-1:0] den_i,
  input  logic [DW:0]   rem_i [3],
  input  logic [NW-1:0] num_i [3],
  input  logic [PW-1:0] pay_i,
  output logic [DW-1:0] den_o,
  output logic [DW:0]   rem_o [3],
  output logic [NW-1:0] num_o [3],
  output logic [PW-1:0] pay_o
);
  logic [DW:0] cur [3];
  always_comb begin
    for (int l = 0; l < 3; l++) cur[l] = {rem_i[l][DW-1:0], num_i[l][NW-1]};
  end
  always_ff @(posedge clk) begin
    den_o <= den_i;
    pay_o <= pay_i;
    for (int l = 0; l < 3; l++) begin
      if (cur[l] >= {1'b0, den_i}) begin
        rem_o[l] <= cur[l] - {1'b0, den_i};
        num_o[l] <= {num_i[l][NW-2:0], 1'b1};
      end else begin
        rem_o[l] <= cur[l];
        num_o[l] <= {num_i[l][NW-2:0], 1'b0};
      end
    end
  end
endmodule

/* design/rotation_matrix_to_quaternion_unit.sv */
// Top level: Shoemake rotation matrix to quaternion conversion in signed fixed point.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
// Usage: drive the nine matrix entries on in_r00..in_r22 and pulse start. busy is
// always low, so an item is accepted at every edge with start high; one item may
// enter every cycle. Each item gives one quaternion on out_quat_w..z, marked by
// out_valid for exactly one cycle; the receiver cannot stall the block.
// Datapath: a select stage, a chain of SW square root cells (one root bit each),
// a numerator stage, a chain of NW divider cells (one quotient bit each, all
// three quotients in lanes), then a saturate/output stage.
// Every stage is registered; a new item may enter while earlier items are still
// in the cell chains, so the block takes one item per cycle.
// Quotients are (|n|*2^F + s) / (2s), rounded, signed, saturated. A zero root
// gives all-zero other components.
// Reset (rst_n low, synchronous) clears the valid bits of every stage; payload
// registers hold junk that is never shown.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r00, in_r01, in_r02,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r10, in_r11, in_r12,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r20, in_r21, in_r22,
  output logic                             out_valid,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_w,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_x,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_y,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_z
);
  localparam int FW = rmq_pkg::FIELD_W;
  // sum width: three entries or the added one, whichever is wider
  localparam int AW = (FW + 3 > FRAC_BITS + 2) ? FW + 3 : FRAC_BITS + 2;
  localparam int TW = AW;                     // radicand width (max 3*2^22 + 2^F)
  localparam int RW = ((TW + FRAC_BITS + 1) / 2) * 2;
  localparam int SW = RW / 2;                 // root width
  localparam int NM = FW + 2;                 // |n| width
  localparam int NW = NM + FRAC_BITS + 1;     // dividend width
  localparam int DW = SW + 1;                 // 2s width
  localparam int PW = 3 * (NM + 1) + 2 + 1 + 1;  // numerators+signs, i, trace flag, valid

  assign busy = 1'b0;

  // ---- stage 0: select case, form radicand and signed numerators
  logic signed [AW-1:0] m [3][3];
  logic signed [AW-1:0] tr, rad, nn [3], dg [3];
  logic [1:0] ii;
  logic tpos;
  logic signed [AW-1:0] num_s [3];   // ordered: slot0 x if trace positive, else w; slot1, slot2 per lane order
  always_comb begin
    m[0][0] = in_r00; m[0][1] = in_r01; m[0][2] = in_r02;
    m[1][0] = in_r10; m[1][1] = in_r11; m[1][2] = in_r12;
    m[2][0] = in_r20; m[2][1] = in_r21; m[2][2] = in_r22;
    tr   = m[0][0] + m[1][1] + m[2][2];
    tpos = tr > 0;
    ii = 2'd0;
    if (m[1][1] > m[0][0]) ii = 2'd1;
    if ((ii == 2'd1 && m[2][2] > m[1][1]) || (ii == 2'd0 && m[2][2] > m[0][0])) ii = 2'd2;
    dg[0] = m[0][0] - m[1][1] - m[2][2];
    dg[1] = m[1][1] - m[2][2] - m[0][0];
    dg[2] = m[2][2] - m[0][0] - m[1][1];
    if (tpos) begin
      rad = tr + AW'(1 << FRAC_BITS);
      nn[0] = m[2][1] - m[1][2];
      nn[1] = m[0][2] - m[2][0];
      nn[2] = m[1][0] - m[0][1];
    end else begin
      unique case (ii)
        2'd0: begin
          rad = dg[0] + AW'(1 << FRAC_BITS);
          nn[0] = m[2][1] - m[1][2];     // w
          nn[1] = m[1][0] + m[0][1];     // y
          nn[2] = m[2][0] + m[0][2];     // z
        end
        2'd1: begin
          rad = dg[1] + AW'(1 << FRAC_BITS);
          nn[0] = m[0][2] - m[2][0];     // w
          nn[1] = m[2][1] + m[1][2];     // z
          nn[2] = m[0][1] + m[1][0];     // x
        end
        default: begin
          rad = dg[2] + AW'(1 << FRAC_BITS);
          nn[0] = m[1][0] - m[0][1];     // w
          nn[1] = m[0][2] + m[2][0];     // x
          nn[2] = m[1][2] + m[2][1];     // y
        end
      endcase
    end
    for (int l = 0; l < 3; l++) num_s[l] = nn[l];
  end

  logic [RW-1:0] rad_r;
  logic [PW-1:0] pay0_r;
  logic          vld0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= start;
    rad_r <= (rad > 0) ? (RW'(rad) << FRAC_BITS) : '0;
    pay0_r <= {1'b1, tpos, ii, num_s[0][NM:0], num_s[1][NM:0], num_s[2][NM:0]};
  end

  // ---- square root chain
  logic          sv   [SW+1];
  logic [RW-1:0] srem [SW+1];
  logic [SW-1:0] sroot[SW+1];
  logic [RW-1:0] srad [SW+1];
  logic [PW-1:0] spay [SW+1];
  assign sv[0] = vld0_r; assign srem[0] = '0; assign sroot[0] = '0;
  assign srad[0] = rad_r; assign spay[0] = pay0_r;
  for (genvar g = 0; g < SW; g++) begin : g_sq
    rmq_sqrt_cell #(.RW(RW), .SW(SW), .PW(PW)) u_cell (
      .clk, .rst_n, .vld_i(sv[g]), .rem_i(srem[g]), .root_i(sroot[g]), .rad_i(srad[g]),
      .pay_i(spay[g]), .vld_o(sv[g+1]), .rem_o(srem[g+1]), .root_o(sroot[g+1]),
      .rad_o(srad[g+1]), .pay_o(spay[g+1]));
  end

  // ---- numerator stage: dividend = |n|*2^F + s
  logic [SW-1:0] s_v;
  logic signed [NM:0] ns [3];
  logic          v1;
  logic [NW-1:0] dnum [3];
  logic [2:0]    neg;
  always_comb begin
    s_v = sroot[SW];
    v1  = spay[SW][PW-1] & sv[SW];
    ns[0] = spay[SW][3*(NM+1)-1 -: NM+1];
    ns[1] = spay[SW][2*(NM+1)-1 -: NM+1];
    ns[2] = spay[SW][NM:0];
    for (int l = 0; l < 3; l++) begin
      neg[l]  = ns[l][NM];
      dnum[l] = (NW'(neg[l] ? NM'(-ns[l]) : NM'(ns[l])) << FRAC_BITS) + NW'(s_v);
    end
  end
  logic [DW-1:0] dden [NW+1];
  logic [DW:0]   drem [NW+1][3];
  logic [NW-1:0] dquo [NW+1][3];
  logic [PW-1:0] dpay [NW+1];
  logic [NW:0]   dvld;
  always_ff @(posedge clk) begin
    dden[0] <= {s_v, 1'b0};
    for (int l = 0; l < 3; l++) begin
      drem[0][l] <= '0;
      dquo[0][l] <= dnum[l];
    end
    // reuse payload: keep flags and signs, stash root in numerator bits
    dpay[0] <= {1'b1, spay[SW][PW-2 -: 3], neg, (PW-7)'(s_v)};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) dvld <= '0;
    else        dvld <= {dvld[NW-1:0], v1};
  end
  for (genvar g = 0; g < NW; g++) begin : g_dv
    rmq_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
      .clk, .den_i(dden[g]), .rem_i(drem[g]), .num_i(dquo[g]), .pay_i(dpay[g]),
      .den_o(dden[g+1]), .rem_o(drem[g+1]), .num_o(dquo[g+1]), .pay_o(dpay[g+1]));
  end

  // ---- output stage: saturate, zero-root case, route lanes to components
  function automatic logic signed [FW-1:0] satq(input logic [NW-1:0] q, input logic ng,
                                                input logic zr);
    logic [NW-1:0] lim;
    logic [NW-1:0] qq;
    begin
      lim = ng ? NW'(rmq_pkg::OUT_MAX) + NW'(1) : NW'(rmq_pkg::OUT_MAX);
      qq  = (q > lim) ? lim : q;
      if (zr) satq = '0;
      else    satq = ng ? FW'(-qq) : FW'(qq);
    end
  endfunction
  logic signed [FW-1:0] lq [3], half;
  logic [SW-1:0] sf;
  logic [1:0] fi;
  logic ft;
  logic [2:0] fn;
  always_comb begin
    sf = SW'(dpay[NW][PW-8:0]);
    ft = dpay[NW][PW-2];
    fi = dpay[NW][PW-3 -: 2];
    fn = dpay[NW][PW-5 -: 3];
    // half root saturates at large FRAC_BITS
    half = (64'(sf >> 1) > 64'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX : FW'(sf >> 1);
    lq[0] = satq(dquo[NW][0], fn[0], sf == '0);
    lq[1] = satq(dquo[NW][1], fn[1], sf == '0);
    lq[2] = satq(dquo[NW][2], fn[2], sf == '0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= dvld[NW];
    if (ft) begin
      out_quat_w <= half; out_quat_x <= lq[0]; out_quat_y <= lq[1]; out_quat_z <= lq[2];
    end else begin
      out_quat_w <= lq[0];
      unique case (fi)
        2'd0: begin out_quat_x <= half; out_quat_y <= lq[1]; out_quat_z <= lq[2]; end
        2'd1: begin out_quat_y <= half; out_quat_z <= lq[1]; out_quat_x <= lq[2]; end
        default: begin out_quat_z <= half; out_quat_x <= lq[1]; out_quat_y <= lq[2]; end
      endcase
    end
  end
endmodule

/* design/rmq_checker.sv */
// Port-level checker for the quaternion unit, bound to the top level.
// Depends only on the top level's ports.
module rmq_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);
  a_never_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_no_x_busy: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(busy))
    else $error("busy unknown");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid));
